// ===== src/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg
// Types and constants shared by the e-paper refresh policy block.
// ----------------------------------------------------------------------------
package erp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned HASH_W = 32;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned LOCK_W = 16;
    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 32;

    localparam logic [CFG_AW-1:0] CFG_MIN_INTERVAL  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PARTIALS_FULL = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FULL_MAX_AGE  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY_LOCKOUT   = 2'd3;

    localparam logic [TIME_W-1:0] RST_MIN_INTERVAL  = 32'd3000;
    localparam logic [CNT_W-1:0]  RST_PARTIALS_FULL = 8'd8;
    localparam logic [TIME_W-1:0] RST_FULL_MAX_AGE  = 32'd1800000;
    localparam logic [LOCK_W-1:0] RST_KEY_LOCKOUT   = 16'd300;

    localparam logic [CNT_W-1:0]  CNT_MAX = 8'hFF;

    typedef enum logic {
        CMD_KEY    = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SLEEP  = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_DASH   = 2'd3
    } t_action;

    typedef struct packed {
        t_cmd              cmd;
        logic [TIME_W-1:0] now_ms;
        logic              key_a_level;
        logic              key_b_level;
        logic              host_display_on;
        logic              link_up;
        logic [HASH_W-1:0] content_hash;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] min_interval_ms;
        logic [CNT_W-1:0]  partials_before_full;
        logic [TIME_W-1:0] full_age_limit;
        logic [LOCK_W-1:0] key_lockout_ms;
    } t_cfg;

    typedef struct packed {
        t_action action;
        logic    full_refresh;
        logic    key_accepted;
    } t_result;

endpackage

// ===== src/erp_policy.sv =====
// ----------------------------------------------------------------------------
// erp_policy
// Policy state and decision logic: key edge/lockout, sleep gating, hash and
// interval gating, full versus partial selection. State advances on i_fire.
// ----------------------------------------------------------------------------
module erp_policy
    import erp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [HASH_W-1:0] r_shown_hash,     n_shown_hash;
    logic [TIME_W-1:0] r_last_draw_time, n_last_draw_time;
    logic [TIME_W-1:0] r_last_full_time, n_last_full_time;
    logic [CNT_W-1:0]  r_partials,       n_partials;
    logic              r_first_draw,     n_first_draw;
    logic              r_force_full,     n_force_full;
    logic              r_sleeping,       n_sleeping;
    logic              r_was_searching,  n_was_searching;
    logic              r_key_a_prev,     n_key_a_prev;
    logic              r_key_b_prev,     n_key_b_prev;
    logic [TIME_W-1:0] r_last_key_time,  n_last_key_time;

    logic [TIME_W-1:0] key_age;
    logic [TIME_W-1:0] draw_age;
    logic [TIME_W-1:0] full_age;
    logic              key_edge;
    logic              key_ok;
    logic              searching;
    logic              redraw;
    logic              full;

    assign key_age   = i_item.now_ms - r_last_key_time;
    assign draw_age  = i_item.now_ms - r_last_draw_time;
    assign full_age  = i_item.now_ms - r_last_full_time;
    assign key_edge  = (r_key_a_prev && !i_item.key_a_level) ||
                       (r_key_b_prev && !i_item.key_b_level);
    assign key_ok    = key_edge && (key_age > {16'd0, i_cfg.key_lockout_ms});
    assign searching = !i_item.link_up;
    assign redraw    = ((i_item.content_hash != r_shown_hash) || r_force_full) &&
                       (r_force_full || (draw_age >= i_cfg.min_interval_ms));
    assign full      = r_force_full || r_first_draw ||
                       (r_partials >= i_cfg.partials_before_full) ||
                       (full_age > i_cfg.full_age_limit) ||
                       (searching != r_was_searching);

    always_comb begin
        n_shown_hash     = r_shown_hash;
        n_last_draw_time = r_last_draw_time;
        n_last_full_time = r_last_full_time;
        n_partials       = r_partials;
        n_first_draw     = r_first_draw;
        n_force_full     = r_force_full;
        n_sleeping       = r_sleeping;
        n_was_searching  = r_was_searching;
        n_key_a_prev     = r_key_a_prev;
        n_key_b_prev     = r_key_b_prev;
        n_last_key_time  = r_last_key_time;
        o_res            = '{action: ACT_NONE, full_refresh: 1'b0, key_accepted: 1'b0};

        case (i_item.cmd)
            CMD_KEY: begin
                if (key_ok) begin
                    n_last_key_time    = i_item.now_ms;
                    n_force_full       = 1'b1;
                    n_shown_hash       = '0;
                    o_res.key_accepted = 1'b1;
                end
                n_key_a_prev = i_item.key_a_level;
                n_key_b_prev = i_item.key_b_level;
            end
            CMD_RENDER: begin
                if (!i_item.host_display_on) begin
                    if (!r_sleeping) begin
                        n_partials         = '0;
                        n_last_full_time   = i_item.now_ms;
                        n_sleeping         = 1'b1;
                        n_shown_hash       = '0;
                        o_res.action       = ACT_SLEEP;
                        o_res.full_refresh = 1'b1;
                    end
                end else begin
                    n_sleeping = 1'b0;
                    if (redraw) begin
                        if (full) begin
                            n_partials       = '0;
                            n_last_full_time = i_item.now_ms;
                        end else if (r_partials != CNT_MAX) begin
                            n_partials = r_partials + CNT_W'(1);
                        end
                        o_res.action       = searching ? ACT_SEARCH : ACT_DASH;
                        o_res.full_refresh = full;
                        n_shown_hash       = i_item.content_hash;
                        n_last_draw_time   = i_item.now_ms;
                        n_first_draw       = 1'b0;
                        n_force_full       = 1'b0;
                        n_was_searching    = searching;
                    end
                end
            end
            default: begin
                o_res = '{action: ACT_NONE, full_refresh: 1'b0, key_accepted: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_hash     <= '0;
            r_last_draw_time <= '0;
            r_last_full_time <= '0;
            r_partials       <= '0;
            r_first_draw     <= 1'b1;
            r_force_full     <= 1'b0;
            r_sleeping       <= 1'b0;
            r_was_searching  <= 1'b1;
            r_key_a_prev     <= 1'b1;
            r_key_b_prev     <= 1'b1;
            r_last_key_time  <= '0;
        end else if (i_fire) begin
            r_shown_hash     <= n_shown_hash;
            r_last_draw_time <= n_last_draw_time;
            r_last_full_time <= n_last_full_time;
            r_partials       <= n_partials;
            r_first_draw     <= n_first_draw;
            r_force_full     <= n_force_full;
            r_sleeping       <= n_sleeping;
            r_was_searching  <= n_was_searching;
            r_key_a_prev     <= n_key_a_prev;
            r_key_b_prev     <= n_key_b_prev;
            r_last_key_time  <= n_last_key_time;
        end
    end

endmodule

// ===== src/eink_refresh_policy_top.sv =====
// ----------------------------------------------------------------------------
// eink_refresh_policy_top
// Path: an accepted item is held in the input register, then the result
//   register takes the policy result after one pass of the policy logic; a
//   stalled result keeps the item waiting in the input register.
// Throughput: one item per cycle; a stalled result holds the input side.
// Reset: synchronous, active low; all but the r_item/r_res data registers reset.
// ----------------------------------------------------------------------------
module eink_refresh_policy_top
    import erp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_key_a_level,
    input  logic              i_key_b_level,
    input  logic              i_host_display_on,
    input  logic              i_link_up,
    input  logic [HASH_W-1:0] i_content_hash,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_action,
    output logic              o_full_refresh,
    output logic              o_key_accepted
);

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_res;
    logic    r_res_valid;
    t_result res;
    logic    advance;

    assign advance    = r_item_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval_ms      <= RST_MIN_INTERVAL;
            r_cfg.partials_before_full <= RST_PARTIALS_FULL;
            r_cfg.full_age_limit       <= RST_FULL_MAX_AGE;
            r_cfg.key_lockout_ms       <= RST_KEY_LOCKOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_INTERVAL:  r_cfg.min_interval_ms      <= i_cfg_wdata;
                CFG_PARTIALS_FULL: r_cfg.partials_before_full <= i_cfg_wdata[CNT_W-1:0];
                CFG_FULL_MAX_AGE:  r_cfg.full_age_limit       <= i_cfg_wdata;
                CFG_KEY_LOCKOUT:   r_cfg.key_lockout_ms       <= i_cfg_wdata[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.cmd             <= t_cmd'(i_cmd);
            r_item.now_ms          <= i_now_ms;
            r_item.key_a_level     <= i_key_a_level;
            r_item.key_b_level     <= i_key_b_level;
            r_item.host_display_on <= i_host_display_on;
            r_item.link_up         <= i_link_up;
            r_item.content_hash    <= i_content_hash;
        end
    end

    erp_policy u_policy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_res_valid;
    assign o_action       = r_res.action;
    assign o_full_refresh = r_res.full_refresh;
    assign o_key_accepted = r_res.key_accepted;

endmodule
